// File: hdl/qsd_pkg.sv
// shared types and constants for the multi-channel quadrature step decoder
// no dependencies
`default_nettype none

package qsd_pkg;

    localparam int CH_W     = 4;
    localparam int PPS_W    = 7;
    localparam int TABLE_W  = 32;
    localparam int CNT_W    = 8;
    localparam int CFG_W    = 32;

    localparam logic [PPS_W-1:0]   PPS_RESET   = 7'd4;
    // standard quadrature table {0,-1,+1,0,+1,0,0,-1,-1,0,0,+1,0,+1,-1,0}
    localparam logic [TABLE_W-1:0] TABLE_RESET = 32'h3443_C11C;
    localparam logic [3:0]         INDEX_MASK  = 4'hF;

    typedef enum logic {
        REG_PULSES_PER_STEP  = 1'b0,
        REG_TRANSITION_TABLE = 1'b1
    } cfg_reg_t;

    typedef logic signed [1:0] step_t;

    localparam step_t STEP_NONE = 2'sb00;
    localparam step_t STEP_POS  = 2'sb01;
    localparam step_t STEP_NEG  = 2'sb11;

    // per-channel stored state
    typedef struct packed {
        logic [1:0]       pair;
        logic [CNT_W-1:0] count;
    } chan_state_t;

endpackage

`default_nettype wire

// File: hdl/qsd_state.sv
// per-channel state store: previous pin pair and pulse count
// depends on qsd_pkg
`default_nettype none

module qsd_state
    import qsd_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IDX_W-1:0] rd_idx,
    output chan_state_t           rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire chan_state_t      wr_data
);

    chan_state_t state_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                state_reg[i] <= '0;
            end
        end else if (wr_en) begin
            state_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = state_reg[rd_idx];

endmodule

`default_nettype wire

// File: hdl/qsd_update.sv
// table lookup, count update and threshold compare for one pin sample
// depends on qsd_pkg
`default_nettype none

module qsd_update
    import qsd_pkg::*;
(
    input  wire chan_state_t         cur,
    input  wire logic [1:0]          pin_pair,
    input  wire logic [TABLE_W-1:0]  table_bits,
    input  wire logic [PPS_W-1:0]    pulses_per_step,
    output chan_state_t              nxt,
    output step_t                    step
);

    logic [3:0]             tidx;
    logic signed [1:0]      delta;
    logic signed [CNT_W-1:0] cnt;
    logic [CNT_W-1:0]       mag;
    logic                   hit;

    always_comb begin
        tidx  = {cur.pair, pin_pair} & INDEX_MASK;
        delta = table_bits[{tidx, 1'b0} +: 2];
        cnt   = $signed(cur.count) + CNT_W'(delta);
        // magnitude after wrap, -128 reads as 128
        mag   = cnt[CNT_W-1] ? CNT_W'(-cnt) : CNT_W'(cnt);
        hit   = (mag >= {1'b0, pulses_per_step});

        nxt.pair = pin_pair;
        if (hit) begin
            nxt.count = '0;
            step      = (!cnt[CNT_W-1] && (cnt != '0)) ? STEP_POS : STEP_NEG;
        end else begin
            nxt.count = cnt;
            step      = STEP_NONE;
        end
    end

endmodule

`default_nettype wire

// File: hdl/multi_channel_quadrature_step_decoder.sv
// top level of the multi-channel quadrature step decoder
// depends on qsd_pkg, qsd_state, qsd_update
//
//  channel   ports                                   width
//  s_        s_valid s_ready s_encoder_index s_pin_pair   4 + 2
//  m_        m_valid m_ready m_step                  2 (signed)
//  config    cfg_we cfg_index cfg_data               1 + 32
//
// one request per cycle sustained while m_ready keeps up; a request passes the
// input register, then lookup/add/compare into the result register that drives m_valid
// state is written back on the same edge that loads the result, so a request
// for the same channel in the next cycle sees the update
// synchronous active-low reset clears all channel state and restores the config defaults
// a stalled result holds the input register; s_ready drops only when both are full
`default_nettype none

module multi_channel_quadrature_step_decoder
    import qsd_pkg::*;
#(
    parameter int NUM_ENCODERS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CH_W-1:0]    s_encoder_index,
    input  wire logic [1:0]         s_pin_pair,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output step_t                   m_step,

    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    // only sixteen channels are reachable through the index field
    localparam int DEPTH = (NUM_ENCODERS < 16) ? NUM_ENCODERS : 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PPS_W-1:0]   pps_reg;
    logic [TABLE_W-1:0] table_reg;

    logic               in_vld_reg;
    logic [CH_W-1:0]    in_ch_reg;
    logic [1:0]         in_pair_reg;

    logic               out_vld_reg;
    logic               out_vld_next;
    step_t              out_step_reg;

    logic               adv;
    logic               in_range;
    logic [IDX_W-1:0]   ch_idx;
    chan_state_t        cur_state;
    chan_state_t        nxt_state;
    step_t              upd_step;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pps_reg   <= PPS_RESET;
            table_reg <= TABLE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PULSES_PER_STEP:  pps_reg   <= cfg_data[PPS_W-1:0];
                REG_TRANSITION_TABLE: table_reg <= cfg_data[TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;

    assign in_range = ({3'b000, in_ch_reg} < 7'(NUM_ENCODERS));
    assign ch_idx   = in_ch_reg[IDX_W-1:0];

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg   <= s_encoder_index;
            in_pair_reg <= s_pin_pair;
        end
    end

    qsd_state #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (ch_idx),
        .rd_data (cur_state),
        .wr_en   (adv && in_range),
        .wr_idx  (ch_idx),
        .wr_data (nxt_state)
    );

    qsd_update u_update (
        .cur             (cur_state),
        .pin_pair        (in_pair_reg),
        .table_bits      (table_reg),
        .pulses_per_step (pps_reg),
        .nxt             (nxt_state),
        .step            (upd_step)
    );

    // result register
    assign out_vld_next = adv || (out_vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_step_reg <= in_range ? upd_step : STEP_NONE;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_step  = out_step_reg;

    // an unknown channel always reports no step
    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !in_range |=> m_step == STEP_NONE)
        else $error("out-of-range channel reported a step");

    // backpressure reaches the input only when both registers are full
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled with a free register");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_vld_reg)
        else $error("valid set after reset");

endmodule

`default_nettype wire

// File: sim/multi_channel_quadrature_step_decoder_tb.sv
// self-checking testbench for the multi-channel quadrature step decoder
// depends on qsd_pkg and multi_channel_quadrature_step_decoder; predicts each step
// from its own copy of the channel state and compares every result in order
module multi_channel_quadrature_step_decoder_tb
    import qsd_pkg::*;
;

    localparam int NUM_CH   = 16;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic [1:0]      pair;
    } sample_t;

    logic             aclk;
    logic             aresetn         = 1'b0;
    logic             s_valid         = 1'b0;
    logic             s_ready;
    logic [CH_W-1:0]  s_encoder_index = '0;
    logic [1:0]       s_pin_pair      = '0;
    logic             m_valid;
    logic             m_ready         = 1'b0;
    step_t            m_step;
    logic             cfg_we          = 1'b0;
    cfg_reg_t         cfg_index       = REG_PULSES_PER_STEP;
    logic [CFG_W-1:0] cfg_data        = '0;

    multi_channel_quadrature_step_decoder #(
        .NUM_ENCODERS(NUM_CH)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_encoder_index(s_encoder_index),
        .s_pin_pair     (s_pin_pair),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_step         (m_step),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // tracked copy of the decoder state
    logic [1:0]              trk_pair [NUM_CH];
    logic signed [CNT_W-1:0] trk_count [NUM_CH];
    logic [PPS_W-1:0]        trk_pps;
    logic [TABLE_W-1:0]      trk_table;

    sample_t sample_queue [$];
    step_t   expected_steps [$];
    int      error_count = 0;

    // sender burst shaping
    sample_t next_sample;
    int      gap_left   = 0;
    int      burst_left = 1;

    // receiver stall pattern
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int mode_left  = 0;
    int ready_mode = 0;

    // stimulus generator: gray-code position and direction per channel
    logic [1:0] gen_pos [NUM_CH];
    logic [1:0] gen_dir [NUM_CH];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic step_t predict_step(input logic [CH_W-1:0] ch, input logic [1:0] pair);
        logic [3:0]              idx;
        logic signed [1:0]       delta;
        logic signed [CNT_W-1:0] cnt;
        int                      mag;
        step_t                   res;
        res = STEP_NONE;
        if (ch < NUM_CH) begin
            idx = {trk_pair[ch], pair};
            trk_pair[ch] = pair;
            delta = trk_table[2*idx +: 2];
            cnt = trk_count[ch] + {{(CNT_W-2){delta[1]}}, delta};
            mag = (cnt < 0) ? -int'(cnt) : int'(cnt);
            if (mag >= int'(trk_pps)) begin
                res = (cnt > 0) ? STEP_POS : STEP_NEG;
                cnt = '0;
            end
            trk_count[ch] = cnt;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // driver: predicts on acceptance, offers queued samples in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            trk_pps = PPS_RESET;
            trk_table = TABLE_RESET;
            for (int i = 0; i < NUM_CH; i++) begin
                trk_pair[i] = '0;
                trk_count[i] = '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PULSES_PER_STEP:  trk_pps = cfg_data[PPS_W-1:0];
                    REG_TRANSITION_TABLE: trk_table = cfg_data[TABLE_W-1:0];
                endcase
            end
            if (s_valid && s_ready)
                expected_steps.push_back(predict_step(s_encoder_index, s_pin_pair));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    next_sample = sample_queue.pop_front();
                    s_valid <= 1'b1;
                    s_encoder_index <= next_sample.ch;
                    s_pin_pair <= next_sample.pair;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // some bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results, drives its own ready pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_steps.size() == 0)
                    report_mismatch($sformatf("step %0d with no request pending", m_step));
                else if (m_step !== expected_steps[0])
                    report_mismatch($sformatf("step got %0d expected %0d",
                                              m_step, expected_steps.pop_front()));
                else
                    void'(expected_steps.pop_front());
            end
            if (hold_taken != hold_asked) begin
                hold_taken++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left <= 0) begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (ready_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic queue_sample(input logic [CH_W-1:0] ch, input logic [1:0] pair);
        sample_t smp;
        smp.ch = ch;
        smp.pair = pair;
        sample_queue.push_back(smp);
        // keep the generator aligned with the pair the block will hold
        gen_pos[ch] = {pair[1], pair[1] ^ pair[0]};
    endtask

    // pct percent of samples follow a legal quadrature walk, the rest are noise
    task automatic queue_random(input int n, input int ch_hi, input int pct);
        logic [CH_W-1:0] ch;
        logic [1:0]      pos;
        for (int k = 0; k < n; k++) begin
            ch = CH_W'($urandom_range(0, ch_hi));
            if ($urandom_range(0, 99) < pct) begin
                if ($urandom_range(0, 15) == 0)
                    gen_dir[ch] = $urandom_range(0, 1) ? 2'd1 : 2'd3;
                pos = gen_pos[ch];
                if ($urandom_range(0, 9) != 0)
                    pos = pos + gen_dir[ch];
                queue_sample(ch, {pos[1], pos[1] ^ pos[0]});
            end else begin
                queue_sample(ch, 2'($urandom_range(0, 3)));
            end
        end
    endtask

    task automatic wait_idle();
        while (sample_queue.size() != 0 || s_valid || expected_steps.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] pps_word, input logic [CFG_W-1:0] table_word,
                             input int n, input int ch_hi, input int pct, input bit hold);
        wait_idle();
        write_reg(REG_PULSES_PER_STEP, pps_word);
        write_reg(REG_TRANSITION_TABLE, table_word);
        if (hold)
            hold_asked++;
        queue_random(n, ch_hi, pct);
    endtask

    initial begin
        for (int i = 0; i < NUM_CH; i++) begin
            gen_pos[i] = '0;
            gen_dir[i] = 2'd1;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset table: one detent each way on channel 0, idle moves on 15
        queue_sample(4'd0, 2'b01);
        queue_sample(4'd0, 2'b11);
        queue_sample(4'd0, 2'b10);
        queue_sample(4'd0, 2'b00);
        queue_sample(4'd0, 2'b10);
        queue_sample(4'd0, 2'b11);
        queue_sample(4'd0, 2'b01);
        queue_sample(4'd0, 2'b00);
        queue_sample(4'd15, 2'b11);
        queue_sample(4'd15, 2'b00);
        queue_sample(4'd15, 2'b11);
        queue_sample(4'd15, 2'b11);

        // zero threshold (upper data bits ignored) and a -2 entry at index 10
        wait_idle();
        write_reg(REG_PULSES_PER_STEP, 32'hFFFF_FF80);
        write_reg(REG_TRANSITION_TABLE, 32'h0020_0000);
        queue_sample(4'd5, 2'b00);
        queue_sample(4'd5, 2'b10);
        queue_sample(4'd5, 2'b10);
        queue_sample(4'd5, 2'b01);
        queue_sample(4'd9, 2'b11);

        wait_idle();
        write_reg(REG_PULSES_PER_STEP, 32'h8000_0002);
        queue_sample(4'd7, 2'b10);
        queue_sample(4'd7, 2'b10);
        queue_sample(4'd7, 2'b10);
        queue_sample(4'd8, 2'b10);
        queue_sample(4'd8, 2'b10);
        queue_sample(4'd8, 2'b01);

        run_phase(CFG_W'(PPS_RESET), TABLE_RESET, 300, NUM_CH - 1, 85, 1'b1);
        run_phase(1, TABLE_RESET, 150, NUM_CH - 1, 90, 1'b0);
        // all -2 deltas drive the count down to -128 before it trips
        run_phase(127, 32'hAAAA_AAAA, 160, 1, 0, 1'b0);
        run_phase(127, 32'h5555_5555, 260, 0, 0, 1'b0);
        run_phase(32'hFFFF_FF80, $urandom(), 100, NUM_CH - 1, 50, 1'b0);
        run_phase($urandom_range(2, 8), $urandom(), 200, NUM_CH - 1, 70, 1'b1);
        run_phase(2, TABLE_RESET, 125, NUM_CH - 1, 80, 1'b1);
        run_phase(2, TABLE_RESET, 125, NUM_CH - 1, 80, 1'b0);
        run_phase($urandom_range(1, 6), $urandom(), 150, NUM_CH - 1, 60, 1'b0);

        wait_idle();
        repeat (8) @(negedge aclk);
        if (error_count == 0)
            $display("multi_channel_quadrature_step_decoder verification clean");
        else
            $display("multi_channel_quadrature_step_decoder verification failed");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("multi_channel_quadrature_step_decoder verification failed");
        $finish;
    end

endmodule
